[design/cws_pkg.sv]
// Package for the circular window sum block.
// Holds shared widths and the default sequence length; no dependencies.
package cws_pkg;

  // Widths fixed by the word format.
  localparam int unsigned DATA_W = 8;
  localparam int unsigned SUM_W  = 14;
  localparam int unsigned WIN_W  = 7;

  // Default for the longest sequence that one load may hold.
  localparam int unsigned MAX_LEN_DEF = 64;

endpackage

[design/cws_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Used by the circular window sum block; depends on nothing.
module cws_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/circular_window_sum.sv]
// Circular window sum: load n bytes (one word per cycle), then emit n window sums.
// After the word that ends the load, the first sum is formed by |window| reads; each
// further sum takes two reads of the single RAM read port, one at each end of the
// window. Input stays stalled until the last sum has been handed to the output.
// Reset clears all control state and the window register to zero; the element RAM is
// not cleared, since every entry is written by the current load before it is read.
module circular_window_sum #(
  parameter int unsigned MaxLen = cws_pkg::MAX_LEN_DEF,
  localparam int unsigned AddrW = (MaxLen > 1) ? $clog2(MaxLen) : 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Configuration: signed window length.
  input  logic                        cfg_we_i,
  input  logic signed [cws_pkg::WIN_W-1:0] cfg_wdata_i,
  // Input words.
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [cws_pkg::DATA_W-1:0]  value_i,
  input  logic                        final_item_i,
  // Result words.
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [cws_pkg::SUM_W-1:0]   window_total_o,
  output logic                        final_result_o
);

  localparam int unsigned DataW = cws_pkg::DATA_W;
  localparam int unsigned SumW  = cws_pkg::SUM_W;
  localparam int unsigned WinW  = cws_pkg::WIN_W;

  // Sequencer states.
  localparam logic [1:0] ST_LOAD  = 2'd0;  // taking input words into the RAM
  localparam logic [1:0] ST_INIT  = 2'd1;  // summing the window of position 0
  localparam logic [1:0] ST_PUT   = 2'd2;  // handing a sum to the output register
  localparam logic [1:0] ST_SLIDE = 2'd3;  // second read of a window slide

  // Operation that the RAM data of the next cycle applies to the running sum.
  localparam logic [1:0] OP_NONE = 2'd0;
  localparam logic [1:0] OP_ADD  = 2'd1;
  localparam logic [1:0] OP_SUB  = 2'd2;

  function automatic logic [AddrW-1:0] ptr_inc(input logic [AddrW-1:0] x,
                                               input logic [AddrW-1:0] last);
    return (x == last) ? '0 : AddrW'(x + 1'b1);
  endfunction

  function automatic logic [AddrW-1:0] ptr_dec(input logic [AddrW-1:0] x,
                                               input logic [AddrW-1:0] last);
    return (x == '0) ? last : AddrW'(x - 1'b1);
  endfunction

  logic signed [WinW-1:0] win_q;
  logic [1:0]             state_q, state_d;
  logic [1:0]             op_q, op_d;
  logic [AddrW-1:0]       count_q, count_d;   // words loaded so far
  logic [AddrW-1:0]       last_q, last_d;     // index of the last loaded word, n - 1
  logic [AddrW-1:0]       pos_q, pos_d;       // position whose sum is formed
  logic [AddrW-1:0]       lead_q, lead_d;     // slide pointer that starts at 0
  logic [AddrW-1:0]       walk_q, walk_d;     // walk pointer, later the far slide pointer
  logic [WinW-1:0]        cnt_q, cnt_d;       // reads left for the first window
  logic                   neg_q, neg_d;       // window looks backward
  logic [SumW-1:0]        sum_q, sum_d;
  logic                   out_valid_q;
  logic [SumW-1:0]        total_q;
  logic                   final_q;

  logic                   in_acc;
  logic                   load_end;
  logic                   out_free;
  logic                   out_load;
  logic [WinW-1:0]        mag;
  logic [AddrW-1:0]       rd_addr;
  logic [DataW-1:0]       rd_data;

  // Magnitude of the window; the pattern for minus sixty-four gives 64.
  assign mag = win_q[WinW-1] ? WinW'(~win_q + 1'b1) : WinW'(win_q);

  assign in_stall_o = (state_q != ST_LOAD);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign load_end   = in_acc && (final_item_i || (count_q == AddrW'(MaxLen - 1)));

  // The output register is free when empty or when its word leaves this cycle.
  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = (state_q == ST_PUT) && out_free;

  // The running sum takes the RAM word that a read issued in the previous cycle returns.
  // Sums are kept modulo 2^14; a slide subtracts and adds back within that range.
  always_comb begin
    case (op_q)
      OP_ADD:  sum_d = sum_q + SumW'(rd_data);
      OP_SUB:  sum_d = sum_q - SumW'(rd_data);
      default: sum_d = sum_q;
    endcase
    if (load_end) begin
      sum_d = '0;
    end
  end

  // Sequencer. Writes happen only while loading and read data is used only afterwards;
  // during the load the read port sits at entry 0 and its data is not applied.
  always_comb begin
    state_d = state_q;
    op_d    = OP_NONE;
    count_d = count_q;
    last_d  = last_q;
    pos_d   = pos_q;
    lead_d  = lead_q;
    walk_d  = walk_q;
    cnt_d   = cnt_q;
    neg_d   = neg_q;
    rd_addr = '0;

    case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          count_d = AddrW'(count_q + 1'b1);
          if (load_end) begin
            // Capture the sequence length and window, then form the first sum.
            count_d = '0;
            last_d  = count_q;
            pos_d   = '0;
            lead_d  = '0;
            walk_d  = '0;
            cnt_d   = mag;
            neg_d   = win_q[WinW-1];
            state_d = (mag == '0) ? ST_PUT : ST_INIT;
          end
        end
      end

      ST_INIT: begin
        // Walk forward over positions 1..k or backward over -1..-k, with wrap.
        if (neg_q) begin
          rd_addr = ptr_dec(walk_q, last_q);
        end else begin
          rd_addr = ptr_inc(walk_q, last_q);
        end
        walk_d = rd_addr;
        op_d   = OP_ADD;
        cnt_d  = WinW'(cnt_q - 1'b1);
        if (cnt_q == WinW'(1)) begin
          state_d = ST_PUT;
        end
      end

      ST_PUT: begin
        if (out_free) begin
          if (pos_q == last_q) begin
            state_d = ST_LOAD;
          end else begin
            // First half of the slide to the next position.
            if (neg_q) begin
              rd_addr = lead_q;
              op_d    = OP_ADD;
            end else begin
              rd_addr = ptr_inc(lead_q, last_q);
              op_d    = OP_SUB;
            end
            lead_d  = ptr_inc(lead_q, last_q);
            pos_d   = AddrW'(pos_q + 1'b1);
            state_d = ST_SLIDE;
          end
        end
      end

      ST_SLIDE: begin
        // Second half: the far end of the window moves by one.
        if (neg_q) begin
          rd_addr = walk_q;
          op_d    = OP_SUB;
        end else begin
          rd_addr = ptr_inc(walk_q, last_q);
          op_d    = OP_ADD;
        end
        walk_d  = ptr_inc(walk_q, last_q);
        state_d = ST_PUT;
      end

      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q       <= '0;
      state_q     <= ST_LOAD;
      op_q        <= OP_NONE;
      count_q     <= '0;
      last_q      <= '0;
      pos_q       <= '0;
      lead_q      <= '0;
      walk_q      <= '0;
      cnt_q       <= '0;
      neg_q       <= 1'b0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        win_q <= cfg_wdata_i;
      end
      state_q <= state_d;
      op_q    <= op_d;
      count_q <= count_d;
      last_q  <= last_d;
      pos_q   <= pos_d;
      lead_q  <= lead_d;
      walk_q  <= walk_d;
      cnt_q   <= cnt_d;
      neg_q   <= neg_d;
      sum_q   <= sum_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output payload; the sum includes the word returned in this cycle.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      total_q <= sum_d;
      final_q <= (pos_q == last_q);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign window_total_o = total_q;
  assign final_result_o = final_q;

  cws_ram #(
    .Width(DataW),
    .Depth(MaxLen)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (in_acc),
    .waddr_i(count_q),
    .wdata_i(value_i),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  // While loading, no RAM read result is waiting to be applied.
  a_load_no_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD) |-> (op_q == OP_NONE))
    else $error("read pending while loading");

  // The first-window walk always has reads left to issue.
  a_init_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INIT) |-> (cnt_q != '0))
    else $error("first-window walk without reads left");

  // Handing over the sum of the last position returns the block to loading.
  a_last_to_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && (pos_q == last_q)) |=> (state_q == ST_LOAD))
    else $error("sequencer did not return to loading after the last sum");

  // The emitted position never runs past the end of the loaded sequence.
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_PUT) || (state_q == ST_SLIDE)) |-> (pos_q <= last_q))
    else $error("position beyond the loaded sequence");

endmodule

[bench/tb_circular_window_sum.sv]
// Self-checking bench for circular_window_sum: loads byte sequences, sweeps the window
// register, and compares every emitted window sum against an in-bench prediction.
// Depends on cws_pkg, the circular_window_sum RTL and the cws_ram it instantiates.
`timescale 1ns / 1ps

module tb_circular_window_sum;

  localparam int unsigned MAX_LOAD = cws_pkg::MAX_LEN_DEF;
  localparam int unsigned DATA_W = cws_pkg::DATA_W;
  localparam int unsigned SUM_W = cws_pkg::SUM_W;
  localparam int unsigned WIN_W = cws_pkg::WIN_W;

  // Quiet time after the last sum of a load, before the window register may change.
  // It gives the block time to return to loading, with margin.
  localparam int SETTLE_CYCLES = 70;
  // Cycles without any accepted word before the run is declared hung.
  // The longest legal quiet stretch comes from the receiver hold-off.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int MAX_REPORTS = 10;

  // One expected result word.
  typedef struct {
    logic [SUM_W-1:0] total;
    logic             last;
  } sum_word_t;

  // Keeps its own copy of the loaded sequence and the window, and turns every
  // completed load into the list of sums the block must emit, in order.
  class window_sum_tracker;
    logic [DATA_W-1:0]       loaded[MAX_LOAD];
    int                      load_count = 0;
    logic signed [WIN_W-1:0] window_len = '0;
    sum_word_t               pending_sums[$];
    int                      failures = 0;

    function int pending();
      return pending_sums.size();
    endfunction

    // Computes the window sum for every position of the loaded sequence.
    // Indices wrap modulo the sequence length, also when |window| >= length.
    function void predict_sums();
      int        n;
      int        k;
      int        mag;
      int        d;
      int        idx;
      sum_word_t word;
      n = load_count;
      k = window_len;
      mag = (k < 0) ? -k : k;
      for (int pos = 0; pos < n; pos++) begin
        word.total = '0;
        for (int t = 1; t <= mag; t++) begin
          d = t % n;
          idx = (k > 0) ? (pos + d) % n : (pos + n - d) % n;
          word.total = word.total + SUM_W'(loaded[idx]);
        end
        word.last = (pos == n - 1);
        pending_sums.push_back(word);
      end
      load_count = 0;
    endfunction

    // Called for every accepted input word.
    function void note_word(logic [DATA_W-1:0] value, logic last);
      loaded[load_count] = value;
      load_count++;
      if (last || load_count == MAX_LOAD) begin
        predict_sums();
      end
    endfunction

    // Called for every accepted result word.
    function void check_sum(logic [SUM_W-1:0] total, logic last);
      sum_word_t want;
      if (pending_sums.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS) begin
          $display("unexpected sum word: total=%0d last=%0b", total, last);
        end
        return;
      end
      want = pending_sums.pop_front();
      if (total !== want.total || last !== want.last) begin
        failures++;
        if (failures <= MAX_REPORTS) begin
          $display("sum mismatch at %0t: total exp %0d got %0d, last exp %0b got %0b",
                   $realtime, want.total, total, want.last, last);
        end
      end
    endfunction
  endclass

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we_i = 1'b0;
  logic signed [WIN_W-1:0]  cfg_wdata_i = '0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic [DATA_W-1:0]        value_i = '0;
  logic                     final_item_i = 1'b0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic [SUM_W-1:0]         window_total_o;
  logic                     final_result_o;

  window_sum_tracker tracker = new();

  // Idling controls shared between the sender and the receiver.
  bit sender_calm = 1'b1;
  bit receiver_calm = 1'b1;
  int hold_len = 0;
  int idle_cycles = 0;

  circular_window_sum #(
    .MaxLen(MAX_LOAD)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .value_i       (value_i),
    .final_item_i  (final_item_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .window_total_o(window_total_o),
    .final_result_o(final_result_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Gap lengths: mostly none, often a few cycles, now and then a long pause.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    else if (r < 92) return $urandom_range(1, 3);
    else return $urandom_range(8, 30);
  endfunction

  // Receiver side. A requested hold-off keeps the stall high for a counted number of
  // cycles so the block backs up into its input; otherwise stalls come in random bursts.
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_len != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold_len) @(negedge clk_i);
        hold_len = 0;
        out_stall_i <= 1'b0;
      end else if (receiver_calm) begin
        out_stall_i <= 1'b0;
      end else if (stall_left != 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        stall_left = pick_gap();
        out_stall_i <= (stall_left != 0);
        if (stall_left != 0) stall_left--;
      end
    end
  end

  // Outputs are sampled at the rising edge, where the stall driven at the falling
  // edge is stable.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      tracker.check_sum(window_total_o, final_result_o);
    end
  end

  // Hang detection: any accepted word on either side restarts the count.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("circular_window_sum test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offers one word, with an optional gap before it, and waits until it is taken.
  // Valid stays high across back-to-back words, so it is never dropped and raised
  // in the same step.
  task automatic send_word(input logic [DATA_W-1:0] v, input logic last);
    int gap;
    gap = sender_calm ? 0 : pick_gap();
    if (gap != 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    value_i <= v;
    final_item_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    tracker.note_word(v, last);
  endtask

  task automatic release_input();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // The sender waits here until every predicted sum has come out, then lets the
  // block settle so it is certainly idle.
  task automatic drain_sums();
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // The window register is only changed with the block idle and no load in progress.
  task automatic set_window(input logic signed [WIN_W-1:0] w);
    drain_sums();
    cfg_wdata_i <= w;
    cfg_we_i <= 1'b1;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.window_len = w;
  endtask

  // Sends one complete sequence; the last word carries the final mark.
  task automatic send_load(input logic [DATA_W-1:0] vals[$]);
    for (int i = 0; i < vals.size(); i++) begin
      send_word(vals[i], i == vals.size() - 1);
    end
    release_input();
  endtask

  // A stretch of random loads under one window setting. Most loads are short; a
  // full-length load is optionally included, and on it the final mark is random, since
  // reaching the maximum length ends the load either way.
  task automatic random_phase(input logic signed [WIN_W-1:0] w, input int budget,
                              input bit with_full_load, input int hold);
    int               sent;
    int               len;
    bit               full_left;
    logic [DATA_W-1:0] v;
    logic             last;
    set_window(w);
    if (hold != 0) hold_len = hold;
    full_left = with_full_load;
    sent = 0;
    while (sent < budget) begin
      if (full_left) begin
        len = MAX_LOAD;
        full_left = 1'b0;
      end else if ($urandom_range(0, 9) < 7) begin
        len = $urandom_range(1, 8);
      end else begin
        len = $urandom_range(9, 20);
      end
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          v = $urandom_range(0, 1) ? '1 : '0;
        end else begin
          v = DATA_W'($urandom_range(0, 255));
        end
        if (i != len - 1) last = 1'b0;
        else if (len == MAX_LOAD) last = 1'($urandom_range(0, 1));
        else last = 1'b1;
        send_word(v, last);
      end
      sent += len;
    end
    release_input();
  endtask

  initial begin : stimulus
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, no idling. The reset window of zero must give all-zero sums.
    send_load('{8'hFF, 8'h00, 8'hAA});
    // A one-word sequence wraps onto itself; a two-word one swaps neighbours.
    set_window(1);
    send_load('{8'hFF});
    send_load('{8'h00, 8'hFF});
    set_window(-1);
    send_load('{8'h01, 8'h02, 8'hFF, 8'h80});
    // Windows much wider than the sequence count each element once per wrap.
    set_window(63);
    send_load('{8'hFF, 8'hFF, 8'hFF});
    // The pattern 7'h40 is a window of minus sixty-four.
    set_window(7'h40);
    send_load('{8'hFF, 8'hFF, 8'h01, 8'h07, 8'hC8});
    set_window(-63);
    send_load('{8'h55, 8'hAA});

    // Random part. The first phase runs with idling on both sides.
    sender_calm = 1'b0;
    receiver_calm = 1'b0;
    random_phase(63, 20, 1'b1, 0);
    // Long receiver hold-off while the sender keeps pushing words back to back,
    // so the block fills up and has to stall its input.
    sender_calm = 1'b1;
    random_phase(7'h40, 20, 1'b0, HOLD_OFF_CYCLES);
    sender_calm = 1'b0;
    random_phase(-63, 20, 1'b1, 0);
    random_phase(1, 20, 1'b0, 0);
    // A stretch with no idling at all.
    sender_calm = 1'b1;
    receiver_calm = 1'b1;
    random_phase(-1, 20, 1'b0, 0);
    sender_calm = 1'b0;
    receiver_calm = 1'b0;
    random_phase(0, 20, 1'b0, 0);
    repeat (3) begin
      random_phase(WIN_W'($urandom_range(0, 127)), 20, 1'b0, 0);
    end

    drain_sums();
    if (tracker.failures == 0 && tracker.pending() == 0) begin
      $display("circular_window_sum test passed");
    end else begin
      $display("circular_window_sum test failed");
    end
    $finish;
  end

endmodule
